// ===== rtl/core/lfu_cache_lru_tiebreak_macros.svh =====
// Assertion macros used by the cache top level.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

// Property holds at every clock edge out of reset.
`define LFUC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LFUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lfuc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_pkg
// Types and constants of the LFU cache with LRU tie break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int CAPACITY    = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int OCC_W       = $clog2(CAPACITY + 1);
  localparam int CFG_W       = 5;
  localparam int APB_AW      = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]       CAP_RESET = 5'd16;

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // register index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [31:0]            key;
    logic [31:0]            value;
    logic [COUNT_WIDTH-1:0] count;
    logic [RANK_W-1:0]      rank;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CAPACITY-1:0] valid;
    logic [OCC_W-1:0]    occ;
  } ctrl_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPD    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/lfuc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_store
// Entry memory: one write and one registered read port.
// ----------------------------------------------------------------------------
module lfuc_store (
  input  logic              clk,
  input  lfuc_pkg::mem_req_t req,
  output lfuc_pkg::entry_t  rdata
);
  import lfuc_pkg::*;

  entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/core/lfuc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_cfg
// APB register file holding the capacity in use.
// ----------------------------------------------------------------------------
module lfuc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfuc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [lfuc_pkg::CFG_W-1:0]  capacity_in_use
);
  import lfuc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // capacity register; writes with paddr[2] set are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (wr_en && paddr[2] == REG_CAPACITY) begin
      capacity_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(32-CFG_W){1'b0}}, capacity_in_use};
    end
  end

endmodule

// ===== rtl/core/lfuc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Sequencer: scan pass for lookup and victim, then read-modify-write pass when an update is due.
// ----------------------------------------------------------------------------
module lfuc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lfuc_pkg::CFG_W-1:0] capacity_in_use,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic [31:0]                key,
  input  logic [31:0]                value,
  output logic                       done,
  output logic                       hit,
  output logic [31:0]                read_value,
  output lfuc_pkg::mem_req_t         mem_req,
  input  lfuc_pkg::entry_t           mem_rdata,
  output lfuc_pkg::ctrl_stat_t       stat
);
  import lfuc_pkg::*;

  state_t              state;
  logic [IDX_W:0]      cnt;
  logic                chk_vld;
  logic [IDX_W-1:0]    chk_idx;
  logic [CAPACITY-1:0] valid, valid_next;
  logic [OCC_W-1:0]    occ, occ_next;

  // latched request
  logic                req_r;
  logic [31:0]         key_r, value_r;

  // scan results
  logic                found, vfound;
  logic [IDX_W-1:0]    fidx, vidx;
  entry_t              frec, vrec;

  // decision
  logic                ins_r, ev_r;
  logic [IDX_W-1:0]    tgt;
  entry_t              trec;

  logic                issue, last_chk;
  logic [31:0]         cap_clamp;
  logic                cap_ok, full, ev, slot_ok, do_upd;
  logic [CAPACITY-1:0] free_mask;
  logic [IDX_W-1:0]    slot;
  entry_t              hit_rec, new_rec, wrec;
  logic                wr_other;

  assign issue    = cnt < (IDX_W+1)'(CAPACITY);
  assign last_chk = chk_vld && (chk_idx == IDX_W'(CAPACITY - 1));
  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign stat     = '{valid: valid, occ: occ};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      chk_vld <= 1'b0;
      valid   <= '0;
      occ     <= '0;
    end else begin
      chk_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt     <= cnt + 1'b1;
            chk_vld <= 1'b1;
          end
          if (last_chk) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          cnt   <= '0;
          state <= do_upd ? ST_UPD : ST_DONE;
        end
        ST_UPD: begin
          if (issue) begin
            cnt     <= cnt + 1'b1;
            chk_vld <= 1'b1;
          end
          if (last_chk) begin
            valid <= valid_next;
            occ   <= occ_next;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read tag follows the read address
  always_ff @(posedge clk) begin
    chk_idx <= cnt[IDX_W-1:0];
  end

  // capacity clamp and decision terms
  always_comb begin
    cap_clamp = (32'(capacity_in_use) > 32'(CAPACITY)) ? 32'(CAPACITY)
                                                       : 32'(capacity_in_use);
    cap_ok    = (cap_clamp != 32'd0);
    full      = (32'(occ) >= cap_clamp);
    ev        = !found && full && vfound;
    for (int i = 0; i < CAPACITY; i++) begin
      free_mask[i] = !valid[i] || (ev && vidx == IDX_W'(i));
    end
    slot    = '0;
    slot_ok = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        slot    = IDX_W'(i);
        slot_ok = 1'b1;
      end
    end
    if (found) begin
      do_upd = (req_r == REQ_GET) || cap_ok;
    end else begin
      do_upd = (req_r == REQ_PUT) && cap_ok && slot_ok;
    end
    // refreshed record of the hit entry
    hit_rec       = frec;
    hit_rec.value = (req_r == REQ_PUT) ? value_r : frec.value;
    hit_rec.count = (frec.count == COUNT_MAX) ? frec.count : frec.count + 1'b1;
    hit_rec.rank  = '0;
    // fresh entry
    new_rec.key   = key_r;
    new_rec.value = value_r;
    new_rec.count = COUNT_WIDTH'(1);
    new_rec.rank  = '0;
  end

  // request latch, scan tracking and decision registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          req_r   <= req_type;
          key_r   <= key;
          value_r <= value;
          found   <= 1'b0;
          vfound  <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (chk_vld && valid[chk_idx]) begin
          if (!found && mem_rdata.key == key_r) begin
            found <= 1'b1;
            fidx  <= chk_idx;
            frec  <= mem_rdata;
          end
          // lowest count, then oldest
          if (!vfound || mem_rdata.count < vrec.count ||
              (mem_rdata.count == vrec.count && mem_rdata.rank > vrec.rank)) begin
            vfound <= 1'b1;
            vidx   <= chk_idx;
            vrec   <= mem_rdata;
          end
        end
      end
      ST_DECIDE: begin
        ins_r      <= !found;
        ev_r       <= ev;
        tgt        <= found ? fidx : slot;
        trec       <= found ? hit_rec : new_rec;
        hit        <= found;
        read_value <= (found && req_r == REQ_GET) ? frec.value : '1;
      end
      default: begin
      end
    endcase
  end

  // write-back of one entry per cycle during the update pass
  always_comb begin
    wr_other = valid[chk_idx] && !(ev_r && chk_idx == vidx);
    wrec     = mem_rdata;
    if (chk_idx == tgt) begin
      wrec = trec;
    end else if (ins_r) begin
      wrec.rank = mem_rdata.rank + 1'b1 -
                  RANK_W'(ev_r && mem_rdata.rank > vrec.rank);
    end else begin
      wrec.rank = mem_rdata.rank + RANK_W'(mem_rdata.rank < frec.rank);
    end
    mem_req.we    = (state == ST_UPD) && chk_vld && (chk_idx == tgt || wr_other);
    mem_req.waddr = chk_idx;
    mem_req.wdata = wrec;
    mem_req.raddr = cnt[IDX_W-1:0];
  end

  // occupancy after the update pass
  always_comb begin
    valid_next = valid;
    occ_next   = occ;
    if (ins_r) begin
      if (ev_r) valid_next[vidx] = 1'b0;
      valid_next[tgt] = 1'b1;
      occ_next = occ + 1'b1 - OCC_W'(ev_r);
    end
  end

endmodule

// ===== rtl/core/lfu_cache_lru_tiebreak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// LFU key-value cache with LRU tie break, entries kept in one memory.
// ----------------------------------------------------------------------------
//  channel   ports                                     handshake
//  config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//  request   req_type key value                        start && !busy
//  result    hit read_value                            done, one-cycle strobe
//
//  A request scans all 16 entries in turn, bound by the memory read port,
//  then decides in ST_DECIDE, and on a get hit, a put hit with nonzero
//  capacity or an insert runs a write-back pass over all entries; the
//  next request is taken the cycle after done.
//  rst is synchronous; it clears all valid bits and occupancy at once.
//  The result receiver cannot stall; the done strobe is never held.
// ----------------------------------------------------------------------------
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfuc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [31:0]                 key,
  input  logic [31:0]                 value,
  output logic                        done,
  output logic                        hit,
  output logic [31:0]                 read_value
);
  import lfuc_pkg::*;

  logic [CFG_W-1:0] capacity_in_use;
  mem_req_t         mem_req;
  entry_t           mem_rdata;
  ctrl_stat_t       stat;

  // configuration register
  lfuc_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .capacity_in_use (capacity_in_use)
  );

  // sequencer
  lfuc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .capacity_in_use (capacity_in_use),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .key             (key),
    .value           (value),
    .done            (done),
    .hit             (hit),
    .read_value      (read_value),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .stat            (stat)
  );

  // entry memory
  lfuc_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // checks
  `LFUC_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `LFUC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not start work")
  `LFUC_ASSERT_ALWAYS(a_occ_match, $countones(stat.valid) == int'(stat.occ), "occupancy mismatch")

endmodule

// ===== tb/lfu_cache_lru_tiebreak_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_tb
// Self-checking bench for the LFU cache with LRU tie break. Get and put
// requests are driven in bursts with random gaps. A cache model in the
// scoreboard predicts the hit flag and the read value of every request, and
// each done strobe is checked against the oldest prediction. Capacity is
// reprogrammed over APB between phases, only while the cache is idle.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_tb;
  import lfuc_pkg::*;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
  } cache_resp_t;

  // Cache model plus queue of predicted responses
  class cache_scoreboard;
    logic                   valid [CAPACITY];
    logic [31:0]            keys  [CAPACITY];
    logic [31:0]            vals  [CAPACITY];
    logic [COUNT_WIDTH-1:0] uses  [CAPACITY];
    logic [RANK_W-1:0]      ranks [CAPACITY];
    int                     occupancy;
    logic [CFG_W-1:0]       cap_reg;
    cache_resp_t            pending_q[$];
    int                     errors;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        valid[i] = 1'b0;
        keys[i]  = '0;
        vals[i]  = '0;
        uses[i]  = '0;
        ranks[i] = '0;
      end
      occupancy = 0;
      cap_reg   = CAP_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [31:0] data);
      if (addr[2] == REG_CAPACITY && addr[1:0] == 2'b00)
        cap_reg = data[CFG_W-1:0];
    endfunction

    function void touch(int s);
      if (uses[s] != COUNT_MAX) uses[s] = uses[s] + 1'b1;
      for (int i = 0; i < CAPACITY; i++)
        if (valid[i] && i != s && ranks[i] < ranks[s]) ranks[i] = ranks[i] + 1'b1;
      ranks[s] = '0;
    endfunction

    // Lowest count goes; among equals the oldest rank
    function void evict_lfu();
      int victim;
      victim = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid[i]) begin
          if (victim < 0 || uses[i] < uses[victim] ||
              (uses[i] == uses[victim] && ranks[i] > ranks[victim]))
            victim = i;
        end
      end
      if (victim >= 0) begin
        for (int i = 0; i < CAPACITY; i++)
          if (valid[i] && ranks[i] > ranks[victim]) ranks[i] = ranks[i] - 1'b1;
        valid[victim] = 1'b0;
        if (occupancy > 0) occupancy--;
      end
    endfunction

    function int first_free();
      for (int i = 0; i < CAPACITY; i++)
        if (!valid[i]) return i;
      return -1;
    endfunction

    function void note_request(logic rtype, logic [31:0] k, logic [31:0] v);
      cache_resp_t r;
      int          found;
      int          slot;
      int          cap;
      cap   = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
      found = -1;
      r.read_value = '1;
      for (int i = 0; i < CAPACITY; i++)
        if (found < 0 && valid[i] && keys[i] == k) found = i;
      if (rtype == REQ_GET) begin
        if (found >= 0) begin
          touch(found);
          r.read_value = vals[found];
        end
      end else if (cap != 0) begin
        if (found >= 0) begin
          vals[found] = v;
          touch(found);
        end else begin
          if (occupancy >= cap) evict_lfu();
          slot = first_free();
          if (slot < 0) begin
            evict_lfu();
            slot = first_free();
          end
          if (slot >= 0) begin
            for (int i = 0; i < CAPACITY; i++)
              if (valid[i]) ranks[i] = ranks[i] + 1'b1;
            valid[slot] = 1'b1;
            keys[slot]  = k;
            vals[slot]  = v;
            uses[slot]  = COUNT_WIDTH'(1);
            ranks[slot] = '0;
            occupancy++;
          end
        end
      end
      r.hit = (found >= 0);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic h, logic [31:0] rv);
      cache_resp_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b read_value=%h", $time, h, rv);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (h !== e.hit) begin
        $display("%0t: hit mismatch expected %0b actual %0b", $time, e.hit, h);
        errors++;
      end
      if (rv !== e.read_value) begin
        $display("%0t: read_value mismatch expected %h actual %h",
                 $time, e.read_value, rv);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [31:0]       key;
  logic [31:0]       value;
  logic              done;
  logic              hit;
  logic [31:0]       read_value;

  cache_scoreboard sb;
  logic [31:0]     key_pool[$];
  int              idle_cycles;

  lfu_cache_lru_tiebreak u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .req_type(req_type), .key(key), .value(value),
    .done(done), .hit(hit), .read_value(read_value)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Result monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(hit, read_value);
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive one request; start stays high so a following request can reuse it
  task automatic send_req(logic rtype, logic [31:0] k, logic [31:0] v);
    start    <= 1'b1;
    req_type <= rtype;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (busy);
    sb.note_request(rtype, k, v);
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // APB write while idle
  task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] c);
    apb_write({REG_CAPACITY, 2'b00}, {$urandom} & ~32'h1f | c);
  endtask

  task automatic new_pool(int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) key_pool.push_back($urandom);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // One phase of random traffic in bursts
  task automatic random_phase(int n_items);
    int burst;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_req(1'($urandom_range(0, 1)), pick_key(), $urandom);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 40));
    end
  endtask

  initial begin
    sb          = new();
    idle_cycles = 0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    start    = 1'b0;
    req_type = REQ_GET;
    key      = '0;
    value    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme keys and values, miss, insert, hit, update
    send_req(REQ_GET, 32'h8000_0000, 32'h0);
    send_req(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(REQ_PUT, 32'h0, 32'hffff_ffff);
    send_req(REQ_PUT, 32'hffff_ffff, 32'h0);
    send_req(REQ_GET, 32'hffff_ffff, 32'h1234_5678);
    send_req(REQ_GET, 32'h8000_0000, 32'h0);
    send_req(REQ_PUT, 32'h0, 32'h5555_aaaa);
    send_req(REQ_GET, 32'h0, 32'h0);
    send_req(REQ_GET, 32'h1, 32'h0);
    // Lower capacity below occupancy: each insert evicts one
    set_capacity(5'd2);
    send_req(REQ_PUT, 32'haaaa_5555, 32'h1);
    send_req(REQ_PUT, 32'h5555_aaaa, 32'h2);
    send_req(REQ_GET, 32'h7fff_ffff, 32'h0);
    // Zero capacity: puts change nothing, hit still reports presence
    set_capacity(5'd0);
    send_req(REQ_PUT, 32'haaaa_5555, 32'h3);
    send_req(REQ_PUT, 32'h1357_9bdf, 32'h4);
    send_req(REQ_GET, 32'haaaa_5555, 32'h0);
    send_req(REQ_GET, 32'h1357_9bdf, 32'h0);
    // Out-of-range register index is ignored
    apb_write(3'b100, 32'h0000_0003);
    send_req(REQ_PUT, 32'h2468_ace0, 32'h5);
    // Capacity above the entry count is clamped
    set_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_req(REQ_PUT, 32'hc000_0000 + i, i);
    send_req(REQ_GET, 32'hc000_0000, 32'h0);
    send_req(REQ_GET, 32'hc000_0011, 32'h0);

    // Random phases over several capacities
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_capacity(5'd1);
        1: set_capacity(5'd16);
        2: set_capacity(5'd0);
        3: set_capacity(5'd31);
        4: set_capacity(5'd4);
        default: set_capacity(CFG_W'($urandom_range(0, 31)));
      endcase
      new_pool($urandom_range(3, 24));
      random_phase(ph == 2 ? 40 : 120);
      if (ph == 5) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lfuc_pkg.sv
rtl/core/lfuc_store.sv
rtl/core/lfuc_cfg.sv
rtl/core/lfuc_ctrl.sv
rtl/core/lfu_cache_lru_tiebreak.sv
tb/lfu_cache_lru_tiebreak_tb.sv
